// ===== rtl/lbpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbpr_pkg - shared types and codes for the lru buffer pool replacement core
// Operation and status codes, the per-frame entry record, and the command
// broadcast from the sequencer to the row of frame cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lbpr_pkg;

  // operation codes carried by the mode field
  localparam logic [1:0] MODE_ACCESS = 2'd0;
  localparam logic [1:0] MODE_UNPIN  = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_VICTIM = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [7:0] PINS_MAX = 8'hFF;

  // one buffer frame record
  typedef struct packed {
    logic [15:0] page;
    logic [7:0]  pins;
    logic        dirty;
    logic        locked;
  } entry_t;

  // flags each cell registers for the sequencer
  typedef struct packed {
    logic hit;
    logic clean_cand;
    logic dirty_cand;
  } cell_stat_t;

  // row update commands
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_MOVE   = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_DEC    = 3'd3,
    CMD_DROP   = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    entry_t  load;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lbpr_cell.sv =====
// ----------------------------------------------------------------------------
// lbpr_cell - one frame of the recency row
// Holds one entry, compares it with the key, and takes its newer neighbor's
// entry when the row closes a gap or moves a page to the most-recent end.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpr_cell #(
  parameter int FRAMES = 16,
  parameter int IDX    = 0
) (
  input  wire                               clk,
  input  wire  [15:0]                       key,
  input  wire  [$clog2(FRAMES+1)-1:0]       occ,
  input  wire  [$clog2(FRAMES)-1:0]         pos,
  input  wire  lbpr_pkg::cell_cmd_t         cmd,
  input  wire  lbpr_pkg::entry_t            nbr,
  output lbpr_pkg::entry_t                  ent,
  output lbpr_pkg::cell_stat_t              stat
);

  localparam int CW = $clog2(FRAMES+1);
  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

  logic          valid;
  logic [CW-1:0] pos_x;
  logic          shift_en;
  logic          load_en;
  logic          dec_en;

  // position decode against the broadcast command
  always_comb begin
    valid    = IDX_C < occ;
    pos_x    = CW'(pos);
    shift_en = ((cmd.op == lbpr_pkg::CMD_MOVE) && (IDX_C >= pos_x) && (IDX_P1 < occ)) ||
               ((cmd.op == lbpr_pkg::CMD_DROP) && (IDX_C >= pos_x));
    load_en  = ((cmd.op == lbpr_pkg::CMD_MOVE) && (IDX_P1 == occ)) ||
               ((cmd.op == lbpr_pkg::CMD_APPEND) && (IDX_C == occ));
    dec_en   = (cmd.op == lbpr_pkg::CMD_DEC) && (IDX_C == pos_x);
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent <= nbr;
    end else if (load_en) begin
      ent <= cmd.load;
    end else if (dec_en && (ent.pins != 8'd0)) begin
      ent.pins <= ent.pins - 8'd1;
    end
  end

  // registered match and victim candidate flags
  always_ff @(posedge clk) begin
    stat.hit        <= valid && (ent.page == key);
    stat.clean_cand <= valid && !ent.dirty && !ent.locked;
    stat.dirty_cand <= valid && ent.dirty && !ent.locked;
  end

endmodule

`default_nettype wire

// ===== rtl/lru_buffer_pool_replacement_core.sv =====
// ----------------------------------------------------------------------------
// lru_buffer_pool_replacement_core - lru buffer list with pins and dirty marks
// A row of FRAMES cells kept in recency order, oldest at cell 0. A small
// sequencer looks up the page, selects the hit or victim, updates the row
// and hands one result per operation to the output register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   in      | input     | in_valid / in_stall | mode, page_id, is_write,
//           |           |                     | pin_request, allow_dirty
//   out     | output    | out_valid/out_stall | status, victim_page
//
// An operation passes through row compare, hit or victim select, row update
// and result load before the input is free again.
// Reset is synchronous and empties the list.
// A stalled output holds the sequencer in its load step; the input stays
// stalled from a transfer until that operation's result reaches the output.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_buffer_pool_replacement_core #(
  parameter int FRAMES = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  mode,
  input  wire  [15:0] page_id,
  input  wire         is_write,
  input  wire         pin_request,
  input  wire         allow_dirty,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  status,
  output logic [15:0] victim_page
);

  localparam int IW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES+1);
  localparam logic [CW-1:0] FULL_C = CW'(FRAMES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_SEL   = 5'b00100,
    S_APPLY = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  // captured operation
  logic [1:0]  op_mode;
  logic [15:0] op_page;
  logic        op_wr;
  logic        op_req;
  logic        op_alw;

  logic [CW-1:0] occ, occ_next;

  // select stage registers
  logic             sel_any;
  logic [IW-1:0]    sel_pos;
  lbpr_pkg::entry_t sel_ent;
  logic [FRAMES-1:0] vic_oh;
  logic             vic_found;

  // result registers
  logic [1:0]  res_status, res_status_next;
  logic [15:0] res_victim, res_victim_next;

  lbpr_pkg::entry_t     ents  [FRAMES];
  lbpr_pkg::cell_stat_t stats [FRAMES];
  lbpr_pkg::cell_cmd_t  cmd;

  logic in_xfer;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // cell row, each cell fed by its newer neighbor
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lbpr_pkg::entry_t nbr;
    if (i == FRAMES - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ents[i+1];
    end
    lbpr_cell #(.FRAMES(FRAMES), .IDX(i)) u_cell (
      .clk  (clk),
      .key  (op_page),
      .occ  (occ),
      .pos  (sel_pos),
      .cmd  (cmd),
      .nbr  (nbr),
      .ent  (ents[i]),
      .stat (stats[i])
    );
  end

  // hit encode and victim candidate isolation
  logic [FRAMES-1:0] hit_v, clean_v, dirty_v, clean_lo, dirty_lo;
  logic [IW-1:0]     pos_c;
  lbpr_pkg::entry_t  ent_c;

  always_comb begin
    pos_c = '0;
    ent_c = '0;
    for (int i = 0; i < FRAMES; i++) begin
      hit_v[i]   = stats[i].hit;
      clean_v[i] = stats[i].clean_cand;
      dirty_v[i] = stats[i].dirty_cand;
      if (stats[i].hit) begin
        pos_c = pos_c | IW'(i);
      end
      ent_c = ent_c | (ents[i] & {$bits(lbpr_pkg::entry_t){stats[i].hit}});
    end
    clean_lo = clean_v & (~clean_v + FRAMES'(1));
    dirty_lo = dirty_v & (~dirty_v + FRAMES'(1));
  end

  always_ff @(posedge clk) begin
    if (state == S_SEL) begin
      sel_any   <= |hit_v;
      sel_pos   <= pos_c;
      sel_ent   <= ent_c;
      vic_found <= (|clean_v) || (op_alw && (|dirty_v));
      if (|clean_v) begin
        vic_oh <= clean_lo;
      end else if (op_alw) begin
        vic_oh <= dirty_lo;
      end else begin
        vic_oh <= '0;
      end
    end
  end

  // victim page pick from the one-hot select
  logic [15:0] vic_page_c;

  always_comb begin
    vic_page_c = '0;
    for (int i = 0; i < FRAMES; i++) begin
      vic_page_c = vic_page_c | (ents[i].page & {16{vic_oh[i]}});
    end
  end

  // row update command and result
  always_comb begin
    cmd             = '0;
    cmd.op          = lbpr_pkg::CMD_NONE;
    occ_next        = occ;
    res_status_next = lbpr_pkg::ST_OK;
    res_victim_next = '0;
    case (op_mode)
      lbpr_pkg::MODE_ACCESS: begin
        if (sel_any) begin
          cmd.op          = lbpr_pkg::CMD_MOVE;
          cmd.load.page   = op_page;
          cmd.load.pins   = (sel_ent.pins == lbpr_pkg::PINS_MAX) ? sel_ent.pins
                                                                 : sel_ent.pins + 8'd1;
          cmd.load.dirty  = sel_ent.dirty | op_wr;
          cmd.load.locked = sel_ent.locked ? 1'b0 : op_req;
        end else if (occ < FULL_C) begin
          cmd.op          = lbpr_pkg::CMD_APPEND;
          cmd.load.page   = op_page;
          cmd.load.pins   = 8'd1;
          cmd.load.dirty  = op_wr;
          cmd.load.locked = op_req;
          occ_next        = occ + CW'(1);
        end else begin
          res_status_next = lbpr_pkg::ST_FULL;
        end
      end
      lbpr_pkg::MODE_UNPIN: begin
        if (sel_any) begin
          cmd.op = lbpr_pkg::CMD_DEC;
        end else begin
          res_status_next = lbpr_pkg::ST_NOTFOUND;
        end
      end
      lbpr_pkg::MODE_DELETE: begin
        if (sel_any) begin
          cmd.op   = lbpr_pkg::CMD_DROP;
          occ_next = occ - CW'(1);
        end else begin
          res_status_next = lbpr_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        if (vic_found) begin
          res_victim_next = vic_page_c;
        end else begin
          res_status_next = lbpr_pkg::ST_NOTFOUND;
        end
      end
    endcase
    if (state != S_APPLY) begin
      cmd.op   = lbpr_pkg::CMD_NONE;
      occ_next = occ;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_xfer) state_next = S_LOOK;
      S_LOOK:  state_next = S_SEL;
      S_SEL:   state_next = S_APPLY;
      S_APPLY: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
    end
  end

  // operation capture on input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_mode <= mode;
      op_page <= page_id;
      op_wr   <= is_write;
      op_req  <= pin_request;
      op_alw  <= allow_dirty;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      res_status <= res_status_next;
      res_victim <= res_victim_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      status      <= res_status;
      victim_page <= res_victim;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lbpr_checker.sv =====
// ----------------------------------------------------------------------------
// lbpr_checker - port-level checks for the lru buffer pool replacement core
// Watches the two channels and the result codes over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpr_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  status,
  input wire [15:0] victim_page
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(victim_page))
    else $error("stalled result changed");

  // one operation at a time: input stalls right after a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an operation is in flight");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == lbpr_pkg::ST_OK) || (status == lbpr_pkg::ST_NOTFOUND) ||
                  (status == lbpr_pkg::ST_FULL))
    else $error("undefined status code");

  // failed operations report no victim
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != lbpr_pkg::ST_OK) |-> victim_page == 16'd0)
    else $error("victim page set on a failed operation");

  // a result transfer cannot follow an input transfer in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !(out_valid && out_stall) |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind lru_buffer_pool_replacement_core lbpr_checker u_lbpr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .victim_page (victim_page)
);

`default_nettype wire

// ===== tb/sv/tb_lru_buffer_pool_replacement_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_buffer_pool_replacement_core - self-checking bench for the lru core
// A queue of page operations feeds a clocked driver. A clocked monitor checks
// every result against an in-bench copy of the recency list. Both channels see
// random gaps and stalls, and a few long output hold-offs fill up the block.
// ----------------------------------------------------------------------------

module tb_lru_buffer_pool_replacement_core;

  localparam int FRAMES       = 16;
  localparam int POOL_SIZE    = 20;
  localparam int RANDOM_ITEMS = 1920;
  localparam int RETIRE_EVERY = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] page;
    logic        wr;
    logic        req;
    logic        alw;
  } pool_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] victim;
  } pool_result_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  mode        = lbpr_pkg::MODE_ACCESS;
  logic [15:0] page_id     = '0;
  logic        is_write    = 1'b0;
  logic        pin_request = 1'b0;
  logic        allow_dirty = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [1:0]  status;
  logic [15:0] victim_page;

  // recency list copy, oldest at index 0
  lbpr_pkg::entry_t lru_frames [FRAMES];
  int     lru_count = 0;

  pool_op_t     pending_ops[$];
  pool_result_t expected_results[$];
  pool_op_t     offered_op;
  pool_result_t want;

  int errors        = 0;
  int accepted_count = 0;
  int results_seen  = 0;
  int cycle_count   = 0;
  int hold_count    = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  int next_hold_at  = 400;
  int mode_count [4] = '{0, 0, 0, 0};
  int status_count [4] = '{0, 0, 0, 0};
  logic hold_off = 1'b0;
  logic [15:0] page_pool [POOL_SIZE];

  lru_buffer_pool_replacement_core #(.FRAMES(FRAMES)) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count++;

  // remove one list position, newer entries close the gap
  function automatic void drop_frame(int pos);
    for (int k = pos; k + 1 < lru_count; k++) lru_frames[k] = lru_frames[k + 1];
    lru_count--;
  endfunction

  // apply one operation to the list copy and return its result
  function automatic pool_result_t predict_pool_op(pool_op_t op);
    pool_result_t     res;
    lbpr_pkg::entry_t ent;
    int               pos;
    res.status = lbpr_pkg::ST_OK;
    res.victim = '0;
    pos = lru_count;
    for (int k = 0; k < lru_count; k++)
      if (pos == lru_count && lru_frames[k].page == op.page) pos = k;
    case (op.mode)
      lbpr_pkg::MODE_ACCESS: begin
        if (pos < lru_count) begin
          ent = lru_frames[pos];
          ent.dirty = ent.dirty | op.wr;
          ent.locked = ent.locked ? 1'b0 : op.req;
          if (ent.pins != lbpr_pkg::PINS_MAX) ent.pins = ent.pins + 8'd1;
          drop_frame(pos);
          lru_frames[lru_count] = ent;
          lru_count++;
        end else if (lru_count < FRAMES) begin
          lru_frames[lru_count] = '{page: op.page, pins: 8'd1, dirty: op.wr, locked: op.req};
          lru_count++;
        end else begin
          res.status = lbpr_pkg::ST_FULL;
        end
      end
      lbpr_pkg::MODE_UNPIN: begin
        if (pos < lru_count) begin
          if (lru_frames[pos].pins != 8'd0) lru_frames[pos].pins = lru_frames[pos].pins - 8'd1;
        end else begin
          res.status = lbpr_pkg::ST_NOTFOUND;
        end
      end
      lbpr_pkg::MODE_DELETE: begin
        if (pos < lru_count) drop_frame(pos);
        else res.status = lbpr_pkg::ST_NOTFOUND;
      end
      default: begin
        // oldest clean unpinned first, then oldest dirty unpinned if allowed
        pos = lru_count;
        for (int k = 0; k < lru_count; k++)
          if (pos == lru_count && !lru_frames[k].dirty && !lru_frames[k].locked) pos = k;
        if (pos == lru_count && op.alw)
          for (int k = 0; k < lru_count; k++)
            if (pos == lru_count && lru_frames[k].dirty && !lru_frames[k].locked) pos = k;
        if (pos < lru_count) res.victim = lru_frames[pos].page;
        else res.status = lbpr_pkg::ST_NOTFOUND;
      end
    endcase
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // stretches where neither side idles
  function automatic bit calm_phase();
    return ((accepted_count / 128) % 5) == 2;
  endfunction

  task automatic queue_op(input logic [1:0] m, input logic [15:0] pg, input logic wr,
                          input logic req, input logic alw);
    pool_op_t op;
    op = '{mode: m, page: pg, wr: wr, req: req, alw: alw};
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // driver: offer queued operations, hold the payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), predict_pool_op(offered_op));
        mode_count[offered_op.mode]++;
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          offered_op = pending_ops.pop_front();
          mode        <= offered_op.mode;
          page_id     <= offered_op.page;
          is_write    <= offered_op.wr;
          pin_request <= offered_op.req;
          allow_dirty <= offered_op.alw;
          in_valid    <= 1'b1;
          gap_left = calm_phase() ? 0 : gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off so the block backs up its input
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      hold_off <= (hold_left > 0);
    end else if (accepted_count >= next_hold_at) begin
      hold_left = HOLD_CYCLES;
      hold_off <= 1'b1;
      next_hold_at += 700;
      hold_count++;
    end
  end

  // receiver stall: random bursts plus the hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0 && !calm_phase() && $urandom_range(0, 3) == 0)
        stall_left = gap_len() + 1;
      if (stall_left > 0) stall_left--;
      out_stall <= hold_off || (stall_left > 0);
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d victim %h", status, victim_page);
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        status_count[want.status]++;
        if (status !== want.status || victim_page !== want.victim) begin
          errors++;
          if (errors <= 10)
            $display("mismatch on result %0d: status exp %0d got %0d, victim exp %h got %h",
                     results_seen, want.status, status, want.victim, victim_page);
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int       rand_total;
    int       next_retire;
    int       idx;
    int       r;
    bit       hammered;
    logic [1:0]  m;
    logic [15:0] pg;

    // directed: empty list, absent pages, lock rules, dirty victims, full list
    queue_op(lbpr_pkg::MODE_VICTIM, 16'h1234, 1'b0, 1'b0, 1'b1);
    queue_op(lbpr_pkg::MODE_UNPIN,  16'hFFFF, 1'b1, 1'b1, 1'b1);
    queue_op(lbpr_pkg::MODE_DELETE, 16'h0000, 1'b1, 1'b1, 1'b1);
    queue_op(lbpr_pkg::MODE_ACCESS, 16'h0000, 1'b0, 1'b0, 1'b0);
    queue_op(lbpr_pkg::MODE_ACCESS, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    queue_op(lbpr_pkg::MODE_VICTIM, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    queue_op(lbpr_pkg::MODE_ACCESS, 16'h0000, 1'b0, 1'b1, 1'b0);
    // hit on a pinned page clears the flag whatever the request
    queue_op(lbpr_pkg::MODE_ACCESS, 16'hFFFF, 1'b0, 1'b1, 1'b1);
    // only a dirty candidate left, not allowed then allowed
    queue_op(lbpr_pkg::MODE_VICTIM, 16'h0000, 1'b1, 1'b1, 1'b0);
    queue_op(lbpr_pkg::MODE_VICTIM, 16'h0000, 1'b0, 1'b0, 1'b1);
    // pin count runs down to zero and stays there
    repeat (3) queue_op(lbpr_pkg::MODE_UNPIN, 16'h0000, 1'b0, 1'b0, 1'b0);
    queue_op(lbpr_pkg::MODE_DELETE, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    for (int k = 0; k < FRAMES - 1; k++)
      queue_op(lbpr_pkg::MODE_ACCESS, 16'h1000 + 16'(k), 1'(k), 1'b0, 1'b0);
    queue_op(lbpr_pkg::MODE_ACCESS, 16'hABCD, 1'b1, 1'b1, 1'b1);
    queue_op(lbpr_pkg::MODE_VICTIM, 16'h5A5A, 1'b0, 1'b0, 1'b0);

    // page pool starts with the pages left in the list
    page_pool[0] = 16'h0000;
    for (int k = 1; k < POOL_SIZE; k++)
      page_pool[k] = (k < FRAMES) ? 16'h1000 + 16'(k - 1) : 16'($urandom_range(0, 16'hFFFF));

    // random: pool traffic, periodic page retirement, one pin-count hammer
    rand_total = 0;
    next_retire = RETIRE_EVERY;
    hammered = 1'b0;
    while (rand_total < RANDOM_ITEMS) begin
      if (rand_total >= next_retire) begin
        for (int k = 0; k < 8; k++) begin
          idx = $urandom_range(0, POOL_SIZE - 1);
          queue_op(lbpr_pkg::MODE_DELETE, page_pool[idx], 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          page_pool[idx] = 16'($urandom_range(0, 16'hFFFF));
        end
        rand_total += 8;
        next_retire += RETIRE_EVERY;
      end else if (!hammered && rand_total >= 900) begin
        // drive one page's pin count past saturation
        for (int k = 0; k < 260; k++)
          queue_op(lbpr_pkg::MODE_ACCESS, page_pool[0], 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        hammered = 1'b1;
        rand_total += 260;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) m = lbpr_pkg::MODE_ACCESS;
        else if (r < 60) m = lbpr_pkg::MODE_UNPIN;
        else if (r < 75) m = lbpr_pkg::MODE_DELETE;
        else m = lbpr_pkg::MODE_VICTIM;
        // stray pages only where they cannot land in the list
        if (m != lbpr_pkg::MODE_ACCESS && $urandom_range(0, 9) == 0)
          pg = 16'($urandom_range(0, 16'hFFFF));
        else pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
        queue_op(m, pg, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
        rand_total++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d transfers: access %0d, unpin %0d, delete %0d, victim %0d",
             accepted_count, mode_count[lbpr_pkg::MODE_ACCESS],
             mode_count[lbpr_pkg::MODE_UNPIN], mode_count[lbpr_pkg::MODE_DELETE],
             mode_count[lbpr_pkg::MODE_VICTIM]);
    $display("checked %0d results: ok %0d, not found %0d, full %0d; %0d output hold-offs",
             results_seen, status_count[lbpr_pkg::ST_OK],
             status_count[lbpr_pkg::ST_NOTFOUND], status_count[lbpr_pkg::ST_FULL],
             hold_count);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
